### design/lbp_pkg.sv
// Package for the LSB-first bit packer: field widths, codes, the controller
// state type and the command/status structs between controller and datapath.
// No dependencies.
package lbp_pkg;

  localparam int WORD_W  = 64;  // packed word width
  localparam int BP_W    = 6;   // bit position within a word
  localparam int LEN_W   = 7;   // put length field
  localparam int WIDTH_W = 10;  // align width field
  localparam int ADDR_W  = 12;  // result word address
  localparam int CFG_W   = 13;  // buffer_words register field
  localparam int GRP_W   = 4;   // word-group index bits used by wide aligns

  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  localparam int DEF_MAX_WORDS      = 4096;
  localparam int DEF_MAX_ALIGN_BITS = 512;

  // Steps of the bit-serial remainder unit: one per bit of the dividend.
  localparam int REM_STEPS = BP_W;

  // Operation codes.
  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_ALIGN = 1'b1;

  // Register index, taken from paddr above the byte offset.
  localparam logic [PADDR_W-3:0] REG_BUFFER_WORDS = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_REM,
    ST_LEN,
    ST_STEP,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load_item;
    logic rem_start;
    logic set_len;
    logic step;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic is_align;
    logic width_zero;
    logic rem_busy;
    logic step_end;
    logic fill;
    logic out_free;
    logic final_ok;
  } status_t;

endpackage

### design/lbp_item_if.sv
// Input channel of the bit packer: valid/ready handshake plus one item.
// Depends on lbp_pkg.
interface lbp_item_if import lbp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [WORD_W-1:0]    field_value;
  logic [LEN_W-1:0]     field_length;
  logic [WIDTH_W-1:0]   align_width;
  logic                 pad_with_ones;

  modport source (
    output valid, operation, field_value, field_length, align_width, pad_with_ones,
    input  ready
  );
  modport sink (
    input  valid, operation, field_value, field_length, align_width, pad_with_ones,
    output ready
  );
endinterface

### design/lbp_result_if.sv
// Output channel of the bit packer: valid/ready handshake plus one word write.
// Depends on lbp_pkg.
interface lbp_result_if import lbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   word_address;
  logic [WORD_W-1:0]   word_bits;
  logic                last_write;

  modport source (
    output valid, word_address, word_bits, last_write,
    input  ready
  );
  modport sink (
    input  valid, word_address, word_bits, last_write,
    output ready
  );
endinterface

### design/lbp_rem.sv
// Bit-serial remainder unit: bit position modulo align width, one bit a cycle.
// Depends on lbp_pkg.
module lbp_rem import lbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [BP_W-1:0]    dividend,
  input  logic [WIDTH_W-1:0] divisor,
  output logic               busy,
  output logic [BP_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(REM_STEPS);

  logic [CNT_W-1:0]   cnt;
  logic [BP_W-1:0]    shift;
  logic [BP_W:0]      trial;
  logic [BP_W-1:0]    rem_next;

  // The partial remainder never exceeds the dividend prefix, so it fits BP_W bits.
  always_comb begin
    trial = {remainder, shift[BP_W-1]};
    if ({{(WIDTH_W-BP_W-1){1'b0}}, trial} >= divisor) begin
      rem_next = BP_W'({{(WIDTH_W-BP_W-1){1'b0}}, trial} - divisor);
    end else begin
      rem_next = trial[BP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(REM_STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift     <= dividend;
      remainder <= '0;
    end else if (busy) begin
      shift     <= shift << 1;
      remainder <= rem_next;
    end
  end

endmodule

### design/lbp_datapath.sv
// Datapath of the bit packer: stream state, item registers, the shared
// insert step, align length computation and the result register.
// Depends on lbp_pkg and lbp_rem.
module lbp_datapath import lbp_pkg::*; #(
  parameter int MAX_WORDS      = DEF_MAX_WORDS,
  parameter int MAX_ALIGN_BITS = DEF_MAX_ALIGN_BITS,
  parameter int BUF_W          = CFG_W
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [BUF_W-1:0]   buffer_words,
  input  logic               in_operation,
  input  logic [WORD_W-1:0]  in_field_value,
  input  logic [LEN_W-1:0]   in_field_length,
  input  logic [WIDTH_W-1:0] in_align_width,
  input  logic               in_pad_with_ones,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  out_word_address,
  output logic [WORD_W-1:0]  out_word_bits,
  output logic               out_last_write
);

  localparam logic [BUF_W-1:0]   MAX_WORDS_V = BUF_W'(MAX_WORDS);
  localparam logic [WIDTH_W-1:0] ALIGN_CAP   =
    (MAX_ALIGN_BITS > (2**WIDTH_W - 1)) ? {WIDTH_W{1'b1}} : WIDTH_W'(MAX_ALIGN_BITS);
  localparam logic [LEN_W-1:0]   WORD_LEN    = LEN_W'(WORD_W);

  // Stream state.
  logic [BUF_W-1:0]   word_position;
  logic [BP_W-1:0]    bit_position;
  logic [WORD_W-1:0]  partial_word;

  // Item registers.
  logic               is_align;
  logic [WORD_W-1:0]  value;
  logic               pad;
  logic [WIDTH_W-1:0] width;
  logic [WIDTH_W-1:0] remaining;
  logic               executed;

  logic [BUF_W-1:0]   lim;
  logic [BP_W-1:0]    rem;
  logic               rem_busy;

  logic [LEN_W-1:0]   put_len;
  logic [WIDTH_W-1:0] width_clamped;
  logic [GRP_W-1:0]   grp_mask;
  logic [WIDTH_W-1:0] offset;
  logic [WIDTH_W-1:0] diff;
  logic [WIDTH_W-1:0] align_len;

  logic [LEN_W-1:0]   to_end;
  logic [LEN_W-1:0]   chunk_span;
  logic [LEN_W-1:0]   slen;
  logic [WORD_W-1:0]  raw;
  logic [WORD_W-1:0]  len_mask;
  logic [WORD_W-1:0]  v;
  logic [WORD_W-1:0]  merged;
  logic [WORD_W-1:0]  overflow;
  logic [LEN_W-1:0]   sum;
  logic               fill;
  logic               last_full;

  lbp_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.rem_start),
    .dividend  (bit_position),
    .divisor   (width),
    .busy      (rem_busy),
    .remainder (rem)
  );

  assign lim = (buffer_words > MAX_WORDS_V) ? MAX_WORDS_V : buffer_words;

  // Item capture: lengths above a word count as a word, wide aligns are capped.
  assign put_len       = (in_field_length > WORD_LEN) ? WORD_LEN : in_field_length;
  assign width_clamped = (in_align_width > ALIGN_CAP) ? ALIGN_CAP : in_align_width;

  // Align length. For widths of a word or more, the offset counts whole words
  // inside the group; the group mask is the word count of the width less one.
  always_comb begin
    grp_mask = width[WIDTH_W-1:BP_W] - 1'b1;
    if (width >= WIDTH_W'(WORD_W)) begin
      offset = {word_position[GRP_W-1:0] & grp_mask, {BP_W{1'b0}}};
    end else begin
      offset = '0;
    end
    diff      = width - offset - {{(WIDTH_W-BP_W){1'b0}}, rem};
    align_len = (diff == width) ? '0 : diff;
  end

  // One insert step. A put goes in whole; padding goes in as many 8-bit chunks
  // as reach or cross the end of the current word, so a step never passes
  // more than one word boundary and the buffer end is seen chunk by chunk.
  always_comb begin
    to_end     = WORD_LEN - {1'b0, bit_position};
    chunk_span = (to_end + LEN_W'(7)) & ~LEN_W'(7);
    if (!is_align) begin
      slen = remaining[LEN_W-1:0];
    end else if (remaining < {{(WIDTH_W-LEN_W){1'b0}}, chunk_span}) begin
      slen = remaining[LEN_W-1:0];
    end else begin
      slen = chunk_span;
    end
    raw      = is_align ? {WORD_W{pad}} : value;
    len_mask = slen[LEN_W-1] ? {WORD_W{1'b1}} : ~({WORD_W{1'b1}} << slen[BP_W-1:0]);
    v        = raw & len_mask;
    merged   = partial_word | (v << bit_position);
    sum      = {1'b0, bit_position} + slen;
    fill     = sum[LEN_W-1];
    overflow = (bit_position == '0) ? '0 : (v >> (WORD_LEN - {1'b0, bit_position}));
    last_full = ((word_position + 1'b1) >= lim);
  end

  always_comb begin
    status.is_align   = is_align;
    status.width_zero = (width == '0);
    status.rem_busy   = rem_busy;
    status.step_end   = (remaining == '0) || (word_position >= lim);
    status.fill       = fill;
    status.out_free   = !out_valid || out_ready;
    status.final_ok   = executed && (word_position < lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
      bit_position  <= '0;
      partial_word  <= '0;
      remaining     <= '0;
      executed      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        remaining <= (in_operation == OP_ALIGN) ? '0
                   : {{(WIDTH_W-LEN_W){1'b0}}, put_len};
        executed  <= 1'b0;
      end else if (cmd.set_len) begin
        remaining <= align_len;
      end else if (cmd.step) begin
        remaining    <= remaining - {{(WIDTH_W-LEN_W){1'b0}}, slen};
        executed     <= 1'b1;
        bit_position <= sum[BP_W-1:0];
        partial_word <= fill ? overflow : merged;
        if (fill) begin
          word_position <= word_position + 1'b1;
        end
      end

      if ((cmd.step && fill) || cmd.emit_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      is_align <= (in_operation == OP_ALIGN);
      value    <= in_field_value;
      pad      <= in_pad_with_ones;
      width    <= width_clamped;
    end
    if (cmd.step && fill) begin
      out_word_address <= word_position[ADDR_W-1:0];
      out_word_bits    <= merged;
      out_last_write   <= last_full;
    end else if (cmd.emit_final) begin
      out_word_address <= word_position[ADDR_W-1:0];
      out_word_bits    <= partial_word;
      out_last_write   <= 1'b1;
    end
  end

endmodule

### design/lbp_ctrl.sv
// Controller of the bit packer: sequences item capture, the align length
// computation, insert steps and the final partial-word transaction.
// Depends on lbp_pkg.
module lbp_ctrl import lbp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
        if (item_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (!status.is_align) begin
          state_next = ST_STEP;
        end else if (status.width_zero) begin
          state_next = ST_IDLE;
        end else begin
          cmd.rem_start = 1'b1;
          state_next    = ST_REM;
        end
      end
      ST_REM: begin
        if (!status.rem_busy) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.set_len = 1'b1;
        state_next  = ST_STEP;
      end
      ST_STEP: begin
        if (status.step_end) begin
          state_next = status.final_ok ? ST_FINAL : ST_IDLE;
        end else if (!status.fill || status.out_free) begin
          cmd.step = 1'b1;
        end
      end
      ST_FINAL: begin
        if (status.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/lsb_first_bit_packer_top.sv
// Top level of the LSB-first bit packer: channels, configuration register and
// the controller/datapath pair. Depends on lbp_pkg, lbp_item_if,
// lbp_result_if, lbp_ctrl and lbp_datapath.
//
// The block appends put fields least-significant bit first to a stream of
// 64-bit words and pads the stream with zeros or ones on an align item. Each
// item yields one result transaction per word it writes: every word it fills,
// carrying the full word, and then the current partial word, with last_write
// set on the final one. Nothing is written at or beyond buffer_words (capped
// at MAX_WORDS); once the stream reaches that point, puts and padding are
// dropped. Items are handled one at a time. A put of nonzero length goes from
// acceptance to the next ready through capture, start, insert, end check and
// final result; a put that fills the last word of the buffer has no final
// result, and an empty or dropped put has neither insert nor final result. An
// align of nonzero width goes through capture, start, a bit-serial remainder
// unit (six shift steps that reduce the bit position by the align width, and
// one in which it reports done), length, one insert step for each word its
// padding lands in, end check and final result. The padding goes in through
// the shared insert step, at most one word per cycle; an align whose padding
// reaches the buffer end has no final result. An align of zero width returns
// to idle after start, and one with nothing to pad, or with no room left in
// the buffer, has no insert step and no final result. A filled word that finds
// the result register still occupied holds the insert step until the sink
// takes the earlier transaction, and the final result waits the same way; a
// new item is accepted while the last result still waits.
// buffer_words sits at APB byte address 0 and should only be written while
// the block is idle; it resets to MAX_WORDS.
module lsb_first_bit_packer_top import lbp_pkg::*; #(
  parameter int MAX_WORDS      = DEF_MAX_WORDS,
  parameter int MAX_ALIGN_BITS = DEF_MAX_ALIGN_BITS
) (
  input  logic               clk,
  input  logic               rst,
  lbp_item_if.sink           item,
  lbp_result_if.source       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // The register must hold MAX_WORDS itself as its reset value.
  localparam int BUF_W = ($clog2(MAX_WORDS + 1) > CFG_W) ? $clog2(MAX_WORDS + 1) : CFG_W;

  logic [BUF_W-1:0] buffer_words;
  logic             reg_hit;
  cmd_t             cmd;
  status_t          status;

  // Configuration port. Writes complete in the access phase; reads are
  // returned combinationally from the register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_BUFFER_WORDS);
  assign prdata  = reg_hit ? PDATA_W'(buffer_words) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_words <= BUF_W'(MAX_WORDS);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      buffer_words <= BUF_W'(pwdata[CFG_W-1:0]);
    end
  end

  lbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  lbp_datapath #(
    .MAX_WORDS      (MAX_WORDS),
    .MAX_ALIGN_BITS (MAX_ALIGN_BITS),
    .BUF_W          (BUF_W)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .buffer_words     (buffer_words),
    .in_operation     (item.operation),
    .in_field_value   (item.field_value),
    .in_field_length  (item.field_length),
    .in_align_width   (item.align_width),
    .in_pad_with_ones (item.pad_with_ones),
    .out_ready        (result.ready),
    .out_valid        (result.valid),
    .out_word_address (result.word_address),
    .out_word_bits    (result.word_bits),
    .out_last_write   (result.last_write)
  );

endmodule

### test/tb_top.sv
// Self-checking testbench for lsb_first_bit_packer_top: directed and random put/align
// items, random idling on both channels, in-order checking of every word write.
// Depends on lbp_pkg, lbp_item_if, lbp_result_if and the packer RTL.
`timescale 1ns / 1ps

module tb_top;
  import lbp_pkg::*;

  // Cycles allowed for an item that writes nothing to finish inside the block.
  localparam int SETTLE_CYCLES = 200;
  localparam int IDLE_PERCENT  = 28;
  localparam logic [PADDR_W-1:0] BUFFER_WORDS_ADDR = {REG_BUFFER_WORDS, 2'b00};
  // Mask on the align width; its bits from bit 6 up select the size of a word group.
  localparam int unsigned GROUP_WIDTH_MASK = 32'hfe0;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] bits;
    logic              last;
  } word_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbp_item_if   item_ch ();
  lbp_result_if res_ch ();

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lsb_first_bit_packer_top dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The run is bounded in simulation time; anything that hangs ends here as a failure.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Shadow of the packer: its configuration and stream state as the block should
  // hold them after every accepted transaction.
  int unsigned       pk_words_cfg = DEF_MAX_WORDS;
  int unsigned       pk_word_pos  = 0;
  int unsigned       pk_bit_pos   = 0;
  logic [WORD_W-1:0] pk_partial   = '0;

  word_write_t item_writes[$];    // word writes of the item being predicted
  word_write_t pending_writes[$]; // word writes still owed by the block, oldest first

  int  mismatches = 0;
  bit  idle_on    = 1'b1;

  function void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  // Writes to the same word within one item collapse into one carrying the
  // final contents. Addresses only ever grow, so the latest entry is enough.
  function void record_write(int unsigned addr, logic [WORD_W-1:0] bits);
    word_write_t w;
    if (item_writes.size() > 0 && item_writes[item_writes.size()-1].addr == addr[ADDR_W-1:0])
    begin
      w = item_writes.pop_back();
      w.bits = bits;
      item_writes.push_back(w);
    end else begin
      w.addr = addr[ADDR_W-1:0];
      w.bits = bits;
      w.last = 1'b0;
      item_writes.push_back(w);
    end
  endfunction

  function void append_bits(logic [WORD_W-1:0] value, int unsigned len);
    int unsigned       limit;
    logic [WORD_W-1:0] v;
    limit = (pk_words_cfg > DEF_MAX_WORDS) ? DEF_MAX_WORDS : pk_words_cfg;
    if (len == 0) return;
    if (len > WORD_W) len = WORD_W;
    // Nothing starts at or past the end of the buffer.
    if (pk_word_pos >= limit) return;
    v = (len >= WORD_W) ? value : value & ((64'd1 << len) - 64'd1);
    pk_partial |= v << pk_bit_pos;
    if (pk_bit_pos + len >= WORD_W) begin
      record_write(pk_word_pos, pk_partial);
      // A word filled from bit zero leaves no overflow behind.
      pk_partial = (pk_bit_pos == 0) ? '0 : v >> (WORD_W - pk_bit_pos);
      pk_word_pos++;
    end
    if (pk_word_pos < limit) record_write(pk_word_pos, pk_partial);
    pk_bit_pos = (pk_bit_pos + len) & (WORD_W - 1);
  endfunction

  function void pad_stream(int unsigned width, logic ones);
    int unsigned offset;
    int unsigned len;
    int unsigned chunk;
    offset = 0;
    if (width == 0) return;
    if (width > DEF_MAX_ALIGN_BITS) width = DEF_MAX_ALIGN_BITS;
    // Wide alignments count the position inside a group of words; the mask is
    // taken as it stands even when the width is not a power of two.
    if (width >= WORD_W)
      offset = (pk_word_pos & (((width & GROUP_WIDTH_MASK) >> 6) - 1)) << 6;
    len = (width - (offset + (pk_bit_pos % width))) % width;
    while (len > 0) begin
      chunk = (len >= 8) ? 8 : len;
      append_bits(ones ? {WORD_W{1'b1}} : {WORD_W{1'b0}}, chunk);
      len -= chunk;
    end
  endfunction

  function void predict_item(logic op, logic [WORD_W-1:0] value, logic [LEN_W-1:0] length,
                             logic [WIDTH_W-1:0] width, logic ones);
    word_write_t w;
    item_writes.delete();
    if (op == OP_PUT) append_bits(value, length);
    else pad_stream(width, ones);
    for (int i = 0; i < item_writes.size(); i++) begin
      w = item_writes[i];
      w.last = (i == item_writes.size() - 1);
      pending_writes.push_back(w);
    end
  endfunction

  // Result side: every accepted transaction is checked against the oldest
  // outstanding write, and ready is dropped at random while idling is on.
  always @(posedge clk) begin : result_check
    word_write_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_writes.size() == 0) begin
          note_mismatch($sformatf("word write to %h with nothing outstanding",
                                  res_ch.word_address));
        end else begin
          want = pending_writes.pop_front();
          if (res_ch.word_address !== want.addr)
            note_mismatch($sformatf("word_address expected %h, got %h",
                                    want.addr, res_ch.word_address));
          if (res_ch.word_bits !== want.bits)
            note_mismatch($sformatf("word_bits at %h expected %h, got %h",
                                    want.addr, want.bits, res_ch.word_bits));
          if (res_ch.last_write !== want.last)
            note_mismatch($sformatf("last_write at %h expected %b, got %b",
                                    want.addr, want.last, res_ch.last_write));
        end
      end
      res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Sends one item: optional idle cycles first, then valid is held until the
  // transaction completes. Valid is left high so the next item can follow
  // directly; wait_idle lowers it.
  task automatic send_item(logic op, logic [WORD_W-1:0] value, logic [LEN_W-1:0] length,
                           logic [WIDTH_W-1:0] width, logic ones);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.operation     <= op;
    item_ch.field_value   <= value;
    item_ch.field_length  <= length;
    item_ch.align_width   <= width;
    item_ch.pad_with_ones <= ones;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_item(op, value, length, width, ones);
  endtask

  // The fields an operation does not use carry random values.
  task automatic send_put(logic [WORD_W-1:0] value, int unsigned length);
    send_item(OP_PUT, value, length[LEN_W-1:0], WIDTH_W'($urandom), 1'($urandom));
  endtask

  task automatic send_align(int unsigned width, logic ones);
    send_item(OP_ALIGN, {$urandom, $urandom}, LEN_W'($urandom), width[WIDTH_W-1:0], ones);
  endtask

  // Stops sending, waits for every outstanding write, then lets the block
  // finish any item that writes nothing.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(logic write, logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= BUFFER_WORDS_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes buffer_words with random bits above the register field, then reads
  // it back. Only call while the block is idle.
  task automatic set_buffer_words(int unsigned words);
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] rdata;
    wdata = $urandom;
    wdata[CFG_W-1:0] = words[CFG_W-1:0];
    apb_transfer(1'b1, wdata, rdata);
    pk_words_cfg = wdata[CFG_W-1:0];
    apb_transfer(1'b0, '0, rdata);
    if (rdata !== PDATA_W'(wdata[CFG_W-1:0]))
      note_mismatch($sformatf("buffer_words read back %h after writing %h",
                              rdata, wdata[CFG_W-1:0]));
  endtask

  task automatic check_register_reset();
    logic [PDATA_W-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    if (rdata !== PDATA_W'(DEF_MAX_WORDS))
      note_mismatch($sformatf("buffer_words after reset is %h", rdata));
  endtask

  // Field extremes for puts: empty, single bit, full width, over-long lengths,
  // word crossings and a full word placed from bit zero.
  task automatic test_put_extremes();
    send_put('1, 0);
    send_put(64'd1, 1);
    send_put('1, 64);
    send_put({$urandom, $urandom}, 100);
    send_put({$urandom, $urandom}, 127);
    send_align(64, 1'b0);
    send_put('1, 64);
    send_put('0, 64);
    send_put({$urandom, $urandom}, 7);
  endtask

  // Align widths: byte, unit, zero, oversized, wide groups, odd widths.
  task automatic test_align_cases();
    send_align(8, 1'b1);
    send_align(1, 1'b1);
    send_align(0, 1'b1);
    send_put({$urandom, $urandom}, 33);
    send_align(512, 1'b1);
    send_put({$urandom, $urandom}, 5);
    send_align(1023, 1'b0);
    send_put({$urandom, $urandom}, 9);
    send_align(200, 1'b1);
    send_put({$urandom, $urandom}, 3);
    send_align(300, 1'b0);
    send_put({$urandom, $urandom}, 50);
    send_align(24, 1'b1);
  endtask

  // Buffer end: the last word is filled, then puts and padding are dropped.
  // A zero-sized buffer drops everything; an oversized one is capped.
  task automatic test_buffer_end();
    send_align(64, 1'b1);
    wait_idle();
    set_buffer_words(pk_word_pos + 1);
    send_put({$urandom, $urandom}, 60);
    send_put('1, 64);
    send_put('1, 5);
    send_align(512, 1'b1);
    wait_idle();
    set_buffer_words(0);
    send_put('1, 64);
    send_align(8, 1'b1);
    wait_idle();
    set_buffer_words(8191);
    send_put({$urandom, $urandom}, 17);
  endtask

  // Mostly puts of ordinary length, with empty, full-width and over-long ones
  // mixed in; aligns favor powers of two up to the widest group.
  task automatic test_random_traffic(int unsigned words, int n_items, bit use_idle);
    int unsigned pick;
    int unsigned length;
    int unsigned width;
    wait_idle();
    set_buffer_words(words);
    idle_on = use_idle;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        if (pick < 8) length = 0;
        else if (pick < 20) length = 64;
        else if (pick < 26) length = $urandom_range(65, 127);
        else length = $urandom_range(1, 63);
        send_put({$urandom, $urandom}, length);
      end else begin
        pick = $urandom_range(99);
        if (pick < 12) width = $urandom_range(0, 1023);
        else if (pick < 60) width = 1 << $urandom_range(0, 9);
        else width = $urandom_range(1, 63);
        send_align(width, 1'($urandom));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    // Every block input has a known value before the first edge.
    item_ch.valid         = 1'b0;
    item_ch.operation     = OP_PUT;
    item_ch.field_value   = '0;
    item_ch.field_length  = '0;
    item_ch.align_width   = '0;
    item_ch.pad_with_ones = 1'b0;
    res_ch.ready          = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_register_reset();
    test_put_extremes();
    test_align_cases();
    test_buffer_end();
    // Plenty of room, random idling on both sides.
    test_random_traffic(DEF_MAX_WORDS, 70, 1'b1);
    // A long stretch at full rate with a random buffer size well ahead.
    test_random_traffic(pk_word_pos + $urandom_range(200, 1000), 60, 1'b0);
    // A buffer that runs out a few words in, so the tail of the phase is dropped.
    test_random_traffic(pk_word_pos + $urandom_range(2, 5), 40, 1'b1);
    // The largest register value, capped by the block.
    test_random_traffic(8191, 67, 1'b1);

    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
